// ===== design/ufc_pkg.sv =====
// Shared types, character constants and helper functions of the form-URL codec.
`default_nettype none
package ufc_pkg;

  localparam int unsigned UFC_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_PCT   = 2'd1,
    HOLD_DIGIT = 2'd2
  } ufc_hold_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [2:0]      zeros;
    logic [1:0]      cnt;
    logic            last;
  } ufc_entry_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } ufc_hex_t;

  function automatic ufc_hex_t hex_value(input logic [7:0] c);
    ufc_hex_t h;
    h = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.valid = 1'b1;
      h.value = 4'(c - CH_ZERO);
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.valid = 1'b1;
      h.value = 4'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LF) begin
      h.valid = 1'b1;
      h.value = 4'(c - CH_LA + 8'd10);
    end
    return h;
  endfunction

  function automatic logic passes(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ) || c == CH_MINUS || c == CH_DOT ||
           c == CH_UNDER;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] c;
    if (v < 4'd10) begin
      c = CH_ZERO + {4'd0, v};
    end else begin
      c = CH_UA + {4'd0, v} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/ufc_front.sv =====
// Front end: accepts source bytes, tracks held escapes and builds result entries.
`default_nettype none
module ufc_front
  import ufc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic        q_full,
  output logic             q_push,
  output ufc_entry_t       q_entry
);

  logic       dir_r;
  logic       dir_nxt;
  ufc_hold_t  held_r;
  ufc_hold_t  held_nxt;
  logic [7:0] digit_r;
  logic [7:0] digit_nxt;
  logic       accept;
  ufc_hex_t   hb;
  ufc_hex_t   hd;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign hb       = hex_value(in_byte);
  assign hd       = hex_value(digit_r);

  always_comb begin
    dir_nxt   = dir_r;
    held_nxt  = held_r;
    digit_nxt = digit_r;
    if (accept && dir_r == DIR_DECODE) begin
      unique case (held_r)
        HOLD_PCT: begin
          if (hb.valid) begin
            held_nxt  = HOLD_DIGIT;
            digit_nxt = in_byte;
          end else begin
            held_nxt = (in_byte == CH_PCT) ? HOLD_PCT : HOLD_NONE;
          end
        end
        HOLD_DIGIT: begin
          if (hb.valid && hd.valid) begin
            held_nxt = HOLD_NONE;
          end else begin
            held_nxt = (in_byte == CH_PCT) ? HOLD_PCT : HOLD_NONE;
          end
        end
        default: begin
          held_nxt = (in_byte == CH_PCT) ? HOLD_PCT : HOLD_NONE;
        end
      endcase
      if (in_last) begin
        held_nxt = HOLD_NONE;
      end
    end
    if (cfg_we) begin
      dir_nxt  = cfg_wdata;
      held_nxt = HOLD_NONE;
    end
  end

  always_comb begin
    logic [1:0] n;
    logic       fresh;
    ufc_hold_t  mid;
    n       = 2'd0;
    fresh   = 1'b0;
    mid     = HOLD_NONE;
    q_entry = '0;
    if (dir_r == DIR_ENCODE) begin
      if (in_byte == CH_SPACE) begin
        q_entry.bytes[0] = CH_PLUS;
        n = 2'd1;
      end else if (passes(in_byte)) begin
        q_entry.bytes[0] = in_byte;
        n = 2'd1;
      end else begin
        q_entry.bytes[0] = CH_PCT;
        q_entry.bytes[1] = hex_char(in_byte[7:4]);
        q_entry.bytes[2] = hex_char(in_byte[3:0]);
        n = 2'd3;
      end
    end else begin
      unique case (held_r)
        HOLD_PCT: begin
          if (hb.valid) begin
            mid = HOLD_DIGIT;
          end else begin
            q_entry.bytes[0] = CH_PCT;
            n     = 2'd1;
            fresh = 1'b1;
          end
        end
        HOLD_DIGIT: begin
          if (hb.valid && hd.valid) begin
            q_entry.bytes[0] = {hd.value, hb.value};
            q_entry.zeros[0] = ({hd.value, hb.value} == 8'd0);
            n = 2'd1;
          end else begin
            q_entry.bytes[0] = CH_PCT;
            q_entry.bytes[1] = digit_r;
            n     = 2'd2;
            fresh = 1'b1;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase
      if (fresh) begin
        if (in_byte == CH_PCT) begin
          mid = HOLD_PCT;
        end else begin
          q_entry.bytes[n] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
          n = 2'(n + 2'd1);
        end
      end
      if (in_last && mid != HOLD_NONE) begin
        q_entry.bytes[n] = CH_PCT;
        n = 2'(n + 2'd1);
        if (mid == HOLD_DIGIT) begin
          q_entry.bytes[n] = in_byte;
          n = 2'(n + 2'd1);
        end
      end
    end
    q_entry.cnt  = n;
    q_entry.last = in_last;
    q_push       = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_ENCODE;
      held_r  <= HOLD_NONE;
      digit_r <= '0;
    end else begin
      dir_r   <= dir_nxt;
      held_r  <= held_nxt;
      digit_r <= digit_nxt;
    end
  end

  a_flush_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last && !cfg_we) |=> (held_r == HOLD_NONE))
    else $error("escape still held after end of string");

  a_last_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |-> q_push)
    else $error("end of string produced no transfer");

endmodule
`default_nettype wire

// ===== design/ufc_queue.sv =====
// Short entry queue between the front end and the output serialiser.
`default_nettype none
module ufc_queue
  import ufc_pkg::*;
#(
  parameter int unsigned QueueDepth = UFC_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  ufc_entry_t push_entry,
  output logic       full,
  input  wire logic  pop,
  output logic       avail,
  output ufc_entry_t head
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(QueueDepth - 1);

  ufc_entry_t            slots_r [QueueDepth];
  logic [PtrW-1:0]       wr_r;
  logic [PtrW-1:0]       wr_nxt;
  logic [PtrW-1:0]       rd_r;
  logic [PtrW-1:0]       rd_nxt;
  logic [CntW-1:0]       count_r;
  logic [CntW-1:0]       count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count_r == CntW'(QueueDepth));
  assign avail   = (count_r != '0);
  assign head    = slots_r[rd_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & avail;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_nxt = (wr_r == PtrMax) ? '0 : PtrW'(wr_r + 1'b1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PtrMax) ? '0 : PtrW'(rd_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CntW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CntW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("transfer into a full queue");

endmodule
`default_nettype wire

// ===== design/ufc_back.sv =====
// Back end: takes queued entries and sends their bytes one transfer at a time.
`default_nettype none
module ufc_back
  import ufc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_avail,
  input  ufc_entry_t      q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end,
  output logic            out_zero_decoded
);

  ufc_entry_t cur_r;
  ufc_entry_t cur_nxt;
  logic       busy_r;
  logic       busy_nxt;
  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       xfer;
  logic       run_end;

  assign run_end          = (idx_r == 2'(cur_r.cnt - 2'd1));
  assign out_valid        = busy_r;
  assign out_byte         = cur_r.bytes[idx_r];
  assign out_zero_decoded = cur_r.zeros[idx_r];
  assign out_run_last     = run_end;
  assign out_string_end   = run_end & cur_r.last;
  assign xfer             = busy_r & ~out_stall;
  assign q_pop            = q_avail & (~busy_r | (xfer & run_end));

  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (xfer) begin
      if (run_end) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = 2'(idx_r + 2'd1);
      end
    end
    if (q_pop) begin
      cur_nxt  = q_head;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  a_index_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r.cnt != 2'd0 && idx_r < cur_r.cnt))
    else $error("serialiser index outside its entry");

endmodule
`default_nettype wire

// ===== design/url_form_codec_top.sv =====
// Top level of the form-URL percent codec.
// Results go through the queue slot, then the back end's entry register, before being sent.
// One result byte per cycle unless out_stall; a source byte gives up to three result bytes.
// A two-entry queue lets the input keep taking bytes while results wait.
// Reset (rst_n low, synchronous) selects encoding, drops any held escape, empties the queue.
`default_nettype none
module url_form_codec_top
  import ufc_pkg::*;
#(
  parameter int unsigned QueueDepth = UFC_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_string_end,
  output logic            out_zero_decoded
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_avail;
  ufc_entry_t q_entry;
  ufc_entry_t q_head;

  ufc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  ufc_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .avail      (q_avail),
    .head       (q_head)
  );

  ufc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_avail          (q_avail),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_string_end   (out_string_end),
    .out_zero_decoded (out_zero_decoded)
  );

endmodule
`default_nettype wire
